### hw/rtl/pcx_pkg.sv
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared constants and types of the pcx run-length encoder
// ----------------------------------------------------------------------------
package pcx_pkg;

   // longest run held before a forced flush
   localparam int MAX_RUN = 63;
   // count byte marker and first value that always needs a count byte
   localparam logic [7:0] MARKER     = 8'hC0;
   localparam logic [7:0] HIGH_VALUE = 8'd192;

   // burst queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef logic [5:0] len_type;

   // code bytes of one flushed run
   typedef struct packed {
      logic [1:0][7:0] bytes;
      logic [1:0]      count;
   } part_type;

   // all code bytes caused by one request, bytes[0] goes out first
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [2:0]      count;
   } burst_type;

endpackage

### hw/rtl/pcx_front.sv
// ----------------------------------------------------------------------------
// pcx_front
// Run tracking: one request per cycle unless stalled, builds its code byte burst
// ----------------------------------------------------------------------------
module pcx_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_pixel_byte,
   input  logic                req_line_end,
   input  logic                queue_full,
   output logic                push,
   output pcx_pkg::burst_type  push_burst
);
   import pcx_pkg::*;

   logic [7:0] run_value_ff;
   logic [7:0] run_value_in;
   len_type    run_length_ff;
   len_type    run_length_in;

   logic       accept;
   logic       run_open;
   logic       differ;
   len_type    new_len;
   logic       flush_new;
   part_type   part_old;
   part_type   part_new;

   // code bytes for a run of value and length (zero length, low value: none)
   function automatic part_type flush_bytes(input logic [7:0] value, input len_type len);
      part_type p;
      p.bytes[0] = value;
      p.bytes[1] = value;
      if (len > 6'd2 || value >= HIGH_VALUE) begin
         p.bytes[0] = MARKER | {2'b00, len};
         p.count    = 2'd2;
      end else begin
         p.count = len[1:0];
      end
      return p;
   endfunction

   assign accept    = req_valid && !queue_full;
   assign req_stall = queue_full;

   always_comb begin
      run_open  = (run_length_ff != '0);
      differ    = run_open && (req_pixel_byte != run_value_ff);
      new_len   = (run_open && !differ) ? run_length_ff + 6'd1 : 6'd1;
      flush_new = (new_len >= len_type'(MAX_RUN)) || req_line_end;

      part_old = flush_bytes(run_value_ff, run_length_ff);
      if (!differ) part_old.count = 2'd0;
      part_new = flush_bytes(req_pixel_byte, new_len);
      if (!flush_new) part_new.count = 2'd0;

      push_burst.bytes = '0;
      case (part_old.count)
         2'd0: begin
            push_burst.bytes[0] = part_new.bytes[0];
            push_burst.bytes[1] = part_new.bytes[1];
         end
         2'd1: begin
            push_burst.bytes[0] = part_old.bytes[0];
            push_burst.bytes[1] = part_new.bytes[0];
            push_burst.bytes[2] = part_new.bytes[1];
         end
         default: begin
            push_burst.bytes[0] = part_old.bytes[0];
            push_burst.bytes[1] = part_old.bytes[1];
            push_burst.bytes[2] = part_new.bytes[0];
            push_burst.bytes[3] = part_new.bytes[1];
         end
      endcase
      push_burst.count = {1'b0, part_old.count} + {1'b0, part_new.count};

      push = accept && (push_burst.count != 3'd0);

      run_value_in  = run_value_ff;
      run_length_in = run_length_ff;
      if (accept) begin
         run_value_in  = req_pixel_byte;
         run_length_in = flush_new ? '0 : new_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff  <= '0;
         run_length_ff <= '0;
      end else begin
         run_value_ff  <= run_value_in;
         run_length_ff <= run_length_in;
      end
   end

endmodule

### hw/rtl/pcx_queue.sv
// ----------------------------------------------------------------------------
// pcx_queue
// Short burst queue between run tracking and byte serializer
// ----------------------------------------------------------------------------
module pcx_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pcx_pkg::burst_type  push_burst,
   output logic                full,
   input  logic                pop,
   output pcx_pkg::burst_type  head,
   output logic                empty
);
   import pcx_pkg::*;

   burst_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff;
   logic [QUEUE_AW-1:0]     wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff;
   logic [QUEUE_AW-1:0]     rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff;
   logic [QUEUE_AW:0]       count_in;

   assign full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_burst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/pcx_back.sv
// ----------------------------------------------------------------------------
// pcx_back
// Byte serializer: unless stalled, walks the head burst one code byte per cycle
// ----------------------------------------------------------------------------
module pcx_back (
   input  logic                clock,
   input  logic                reset,
   input  pcx_pkg::burst_type  head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_code_byte,
   output logic                rsp_last_of_item
);
   import pcx_pkg::*;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [7:0] code_byte_ff;
   logic [7:0] code_byte_in;
   logic       last_ff;
   logic       last_in;
   logic [1:0] idx_ff;
   logic [1:0] idx_in;

   logic       out_free;
   logic       load;
   logic       last_byte;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      load      = out_free && !empty;
      last_byte = ({1'b0, idx_ff} == (head.count - 3'd1));
      pop       = load && last_byte;

      rsp_valid_in = out_free ? !empty : rsp_valid_ff;
      code_byte_in = load ? head.bytes[idx_ff] : code_byte_ff;
      last_in      = load ? last_byte : last_ff;
      idx_in       = idx_ff;
      if (load) idx_in = last_byte ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      code_byte_ff <= code_byte_in;
      last_ff      <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_code_byte    = code_byte_ff;
   assign rsp_last_of_item = last_ff;

endmodule

### hw/rtl/pcx_rle_encoder.sv
// a request's first code byte passes the burst queue and the output register
// requests enter and code bytes leave at one per cycle each, unless stalled
// the serializer sets the output rate, a request may cause up to four bytes
// a four-entry burst queue takes up the difference before req_stall rises
// reset (synchronous, active high) drops any open run and empties the queue
// ----------------------------------------------------------------------------
// pcx_rle_encoder
// Streaming PCX run-length encoder for one line of index bytes
// ----------------------------------------------------------------------------
module pcx_rle_encoder (
   input  logic       clock,
   input  logic       reset,
   // request channel: one index byte, line_end marks the last byte of a line
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_pixel_byte,
   input  logic       req_line_end,
   // result channel: count byte, run value or literal
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_code_byte,
   output logic       rsp_last_of_item
);
   import pcx_pkg::*;

   logic      push;
   burst_type push_burst;
   logic      queue_full;
   logic      pop;
   burst_type head;
   logic      queue_empty;

   // front: tracks the open run, flushes it on a new value, full length
   // or line end, and turns every request into a burst of 0 to 4 bytes
   pcx_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_byte (req_pixel_byte),
      .req_line_end   (req_line_end),
      .queue_full     (queue_full),
      .push           (push),
      .push_burst     (push_burst)
   );

   // queue: only requests that produce bytes take an entry
   pcx_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_burst (push_burst),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .empty      (queue_empty)
   );

   // back: registers one byte per cycle when not stalled, flags the final byte
   pcx_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .empty            (queue_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_byte    (rsp_code_byte),
      .rsp_last_of_item (rsp_last_of_item)
   );

endmodule

### hw/rtl/pcx_checker.sv
// ----------------------------------------------------------------------------
// pcx_checker
// Port-level checks of the pcx run-length encoder
// ----------------------------------------------------------------------------
module pcx_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_line_end,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_code_byte,
   input logic       rsp_last_of_item
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_byte)
                                 && $stable(rsp_last_of_item))
      else $error("stalled result changed");

   // reset leaves an empty pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not empty after reset");

   // line end on an idle block brings a result to the output
   a_line_end_out: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_line_end && !rsp_valid
      && !$past(req_valid && !req_stall) |-> ##2 rsp_valid)
      else $error("line end produced no result");

   // a result with the last flag low is followed by more of the same request
   a_burst_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_item |=> rsp_valid)
      else $error("burst broken");

endmodule

bind pcx_rle_encoder pcx_checker u_pcx_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_line_end     (req_line_end),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_code_byte    (rsp_code_byte),
   .rsp_last_of_item (rsp_last_of_item)
);

### tb/pcx_rle_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcx_rle_encoder_tb
// Self-checking bench for the pcx run-length encoder. A short table of
// directed requests covers the value and run-length corners. It is followed
// by random lines made of runs of random length. Every code byte is checked
// against typed bytes or a bench-side encoder model, with random gaps and stalls on both
// channels.
// ----------------------------------------------------------------------------
module pcx_rle_encoder_tb;
   import pcx_pkg::*;

   localparam int N_ROWS        = 23;
   localparam int RANDOM_PIXELS = 225;

   // dut ports, every input known from time zero
   logic       clock          = 1'b0;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic [7:0] req_pixel_byte = 8'h00;
   logic       req_line_end   = 1'b0;
   logic       rsp_stall      = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_code_byte;
   logic       rsp_last_of_item;

   // one expected code byte and whether it closes its request's burst
   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } code_slot_type;

   // directed row: n_exp < 0 means the encoder model supplies the bytes
   typedef struct {
      logic [7:0] pix;
      logic       fin;
      int         reps;
      int         n_exp;
      logic [7:0] e0, e1, e2, e3;
   } stim_row_type;

   stim_row_type directed_rows [N_ROWS] = '{
      // lone low value right after reset is a literal
      '{8'h00, 1'b1,  1,  1, 8'h00, 8'h00, 8'h00, 8'h00},
      // lone high values always take a count byte, 8'hBF just below does not
      '{8'hFF, 1'b1,  1,  2, 8'hC1, 8'hFF, 8'h00, 8'h00},
      '{8'hC0, 1'b1,  1,  2, 8'hC1, 8'hC0, 8'h00, 8'h00},
      '{8'hBF, 1'b1,  1,  1, 8'hBF, 8'h00, 8'h00, 8'h00},
      // run of two low bytes goes out as two literals, extension is silent
      '{8'h05, 1'b0,  1,  0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h05, 1'b1,  1,  2, 8'h05, 8'h05, 8'h00, 8'h00},
      // run of three takes a count byte
      '{8'h07, 1'b0,  2, -1, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h07, 1'b1,  1,  2, 8'hC3, 8'h07, 8'h00, 8'h00},
      // new value with line end flushes old run, then the new one
      '{8'h11, 1'b0,  1,  0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h22, 1'b1,  1,  2, 8'h11, 8'h22, 8'h00, 8'h00},
      // same with two high values: four bytes from one request
      '{8'hC5, 1'b0,  1,  0, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hD0, 1'b1,  1,  4, 8'hC1, 8'hC5, 8'hC1, 8'hD0},
      // run filled to the limit flushes on its last byte, next equal byte is new
      '{8'h33, 1'b0, 63, -1, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h33, 1'b1,  1,  1, 8'h33, 8'h00, 8'h00, 8'h00},
      '{8'hAA, 1'b0,  2, -1, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h5A, 1'b1,  1,  3, 8'hAA, 8'hAA, 8'h5A, 8'h00},
      // high value past the limit, remainder closed by line end
      '{8'hE0, 1'b0, 64, -1, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hE0, 1'b1,  1, -1, 8'h00, 8'h00, 8'h00, 8'h00},
      // flush on value change without line end
      '{8'h80, 1'b0,  3, -1, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h81, 1'b0,  1, -1, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h81, 1'b1,  1, -1, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h7F, 1'b0,  1, -1, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'hFE, 1'b1,  1, -1, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   // encoder model state, matches the block after reset
   logic [7:0] run_val = 8'h00;
   logic [5:0] run_len = 6'd0;

   code_slot_type pending_codes [$];

   int errors        = 0;
   int n_requests    = 0;
   int n_codes       = 0;
   int n_limit_hits  = 0;
   int longest_burst = 0;
   bit tight_phase   = 1'b0;

   pcx_rle_encoder u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_byte   (req_pixel_byte),
      .req_line_end     (req_line_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_code_byte    (rsp_code_byte),
      .rsp_last_of_item (rsp_last_of_item)
   );

   always #5 clock = ~clock;

   // close the open run, appending its code bytes to the burst
   function automatic void close_run(inout burst_type b);
      int k;
      if (run_len == 0) return;
      if (run_len > 2 || run_val >= HIGH_VALUE) begin
         b.bytes[b.count[1:0]] = MARKER | {2'b00, run_len};
         b.count               = b.count + 3'd1;
         b.bytes[b.count[1:0]] = run_val;
         b.count               = b.count + 3'd1;
      end else begin
         for (k = 0; k < run_len; k++) begin
            b.bytes[b.count[1:0]] = run_val;
            b.count               = b.count + 3'd1;
         end
      end
      run_len = 6'd0;
   endfunction

   // code bytes caused by one accepted pixel, updates the run state
   function automatic burst_type encode_pixel(input logic [7:0] pix, input logic fin);
      burst_type b;
      b = '0;
      // a different byte ends the open run first
      if (run_len != 0 && pix != run_val) close_run(b);
      if (run_len == 0) begin
         run_val = pix;
         run_len = 6'd1;
      end else begin
         run_len = run_len + 6'd1;
      end
      // full run or end of line forces a flush in the same request
      if (run_len >= MAX_RUN) n_limit_hits++;
      if (run_len >= MAX_RUN || fin) close_run(b);
      return b;
   endfunction

   function automatic void queue_burst(input burst_type b);
      int            i;
      code_slot_type slot;
      for (i = 0; i < b.count; i++) begin
         slot.code     = b.bytes[i[1:0]];
         slot.last     = (i == b.count - 1);
         pending_codes = {pending_codes, slot};
      end
      if (b.count > longest_burst) longest_burst = b.count;
   endfunction

   // idle cycles before the next request: mostly none, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (tight_phase || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   // present one pixel, hold it until accepted, then predict its code bytes;
   // valid stays high across back-to-back requests
   task automatic send_pixel(input logic [7:0] pix, input logic fin, input int gap,
                             output burst_type codes);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_byte <= pix;
      req_line_end   <= fin;
      do @(posedge clock); while (req_stall);
      codes = encode_pixel(pix, fin);
      n_requests++;
   endtask

   // result side back-pressure: short stalls mostly, now and then a long one,
   // and some stretches with none at all
   initial begin : drive_rsp_stall
      forever begin
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, tight_phase ? 40 : 6)) @(posedge clock);
         if ($urandom_range(0, 7) != 0) begin
            rsp_stall <= 1'b1;
            if ($urandom_range(0, 99) < 85)
               repeat ($urandom_range(1, 3)) @(posedge clock);
            else
               repeat ($urandom_range(10, 30)) @(posedge clock);
         end
      end
   end

   // compare every accepted code byte with the oldest expected one
   always @(posedge clock) begin : check_codes
      code_slot_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_codes++;
         if (pending_codes.size() == 0) begin
            $error("unexpected code byte %02h (last %0b)", rsp_code_byte, rsp_last_of_item);
            errors++;
         end else begin
            want = pending_codes.pop_front();
            if (rsp_code_byte !== want.code) begin
               $error("code_byte: expected %02h, got %02h", want.code, rsp_code_byte);
               errors++;
            end
            if (rsp_last_of_item !== want.last) begin
               $error("last_of_item: expected %0b, got %0b", want.last, rsp_last_of_item);
               errors++;
            end
         end
      end
   end

   // main stimulus
   initial begin : stimulus
      burst_type    got;
      burst_type    typed;
      stim_row_type row;
      logic [7:0]   pix;
      logic [7:0]   prev_pix;
      logic         fin;
      int           run_n;
      int           sent_random;
      int           r;
      int           k;
      int           n_directed;

      sent_random = 0;
      prev_pix    = 8'h00;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, typed bytes where they are obvious
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         for (k = 0; k < row.reps; k++) begin
            fin = row.fin && (k == row.reps - 1);
            send_pixel(row.pix, fin, pick_gap(), got);
            if (row.n_exp >= 0) begin
               typed          = '0;
               typed.bytes[0] = row.e0;
               typed.bytes[1] = row.e1;
               typed.bytes[2] = row.e2;
               typed.bytes[3] = row.e3;
               typed.count    = 3'(row.n_exp);
               queue_burst(typed);
            end else begin
               queue_burst(got);
            end
         end
      end
      n_directed = n_requests;

      // random lines built from runs of random length and value
      while (sent_random < RANDOM_PIXELS) begin
         if ($urandom_range(0, 15) == 0) tight_phase = !tight_phase;
         r = $urandom_range(0, 3);
         case (r)
            0:       pix = 8'($urandom_range(0, 255));
            1:       pix = 8'($urandom_range(188, 196));   // around the count byte threshold
            2:       pix = prev_pix;                        // continue the previous run
            default: pix = 8'($urandom);
         endcase
         r = $urandom_range(0, 19);
         if (r < 10)      run_n = $urandom_range(1, 2);
         else if (r < 19) run_n = $urandom_range(3, 8);
         else             run_n = $urandom_range(55, 70);   // may cross the run limit
         for (k = 0; k < run_n; k++) begin
            fin = ($urandom_range(0, 24) == 0) ||
                  (k == run_n - 1 && $urandom_range(0, 3) == 0);
            send_pixel(pix, fin, pick_gap(), got);
            queue_burst(got);
            sent_random++;
         end
         prev_pix = pix;
      end
      req_valid <= 1'b0;

      // drain, then wait on to catch stray code bytes
      while (pending_codes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("encoded %0d pixel requests (%0d directed) into %0d code bytes",
               n_requests, n_directed, n_codes);
      $display("%0d runs reached the %0d-byte limit, longest burst %0d bytes",
               n_limit_hits, MAX_RUN, longest_burst);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin : watchdog
      #(5_000_000);
      $display("timeout with %0d code bytes still expected", pending_codes.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### files.f
hw/rtl/pcx_pkg.sv
hw/rtl/pcx_front.sv
hw/rtl/pcx_queue.sv
hw/rtl/pcx_back.sv
hw/rtl/pcx_rle_encoder.sv
hw/rtl/pcx_checker.sv
tb/pcx_rle_encoder_tb.sv
